// ===== src/rsfr_pkg.sv =====
// rsfr_pkg: types, codes and sizes shared by the status frame receiver.
// No dependencies; every other file of the block uses it by scoped names.
package rsfr_pkg;

  localparam int unsigned PayloadDepth = 14;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  localparam logic [7:0] SyncReset  = 8'h7A;
  localparam logic [7:0] TypeReset  = 8'hF8;
  localparam logic [7:0] CmdOdom    = 8'hAA;
  localparam logic [7:0] CmdRange   = 8'hBB;
  localparam logic [7:0] OdomMinLen = 8'd16;
  localparam logic [7:0] RangeMinLen = 8'd8;

  // configuration register indexes
  localparam logic CfgSync = 1'b0;
  localparam logic CfgType = 1'b1;

  typedef enum logic [2:0] {
    StOdom     = 3'd0,
    StRanges   = 3'd1,
    StOther    = 3'd2,
    StChkErr   = 3'd3,
    StWrongType = 3'd4,
    StTooShort = 3'd5
  } status_e;

  // one finished frame, as classified by the parser
  typedef struct packed {
    status_e                       status;
    logic [7:0]                    command;
    logic [PayloadDepth-1:0][7:0]  payload;
  } frame_rec_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

// ===== src/robot_status_frame_receiver.sv =====
// robot_status_frame_receiver: top level of the status frame receiver.
// Depends on rsfr_pkg, rsfr_parser, rsfr_queue and rsfr_format.
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i/in_stall_o   byte_in_i
//   result    out        out_valid_o/out_stall_i status_o .. range_bytes_o
//   config    in         cfg_we_i                cfg_index_i, cfg_data_i
//
// One byte is taken every cycle in which in_valid_i is high and in_stall_o is low.
// A frame's result passes through the queue and the output register after its checksum byte.
// Reset clears the parser, queue and output valid, and loads sync 0x7A and
// type 0xF8; the payload store holds no reset value.
// in_stall_o rises only while two finished frames wait in the queue.
module robot_status_frame_receiver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [7:0]         command_o,
  output logic [15:0]        yaw_degrees_o,
  output logic signed [31:0] left_count_o,
  output logic signed [31:0] right_count_o,
  output logic signed [15:0] linear_speed_o,
  output logic signed [15:0] angular_speed_o,
  output logic [47:0]        range_bytes_o
);

  rsfr_pkg::frame_rec_t  push_rec, pop_rec;
  rsfr_pkg::queue_stat_t qstat;
  logic push, pop, accept;

  // hold input bytes only while the queue cannot take another frame
  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !in_stall_o;

  // front: parse and classify
  rsfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_in_i   (byte_in_i),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // decouple front and back
  rsfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .stat_o     (qstat)
  );

  // back: format fields and drive the result transaction
  rsfr_format u_format (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .qstat_i         (qstat),
    .rec_i           (pop_rec),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .command_o       (command_o),
    .yaw_degrees_o   (yaw_degrees_o),
    .left_count_o    (left_count_o),
    .right_count_o   (right_count_o),
    .linear_speed_o  (linear_speed_o),
    .angular_speed_o (angular_speed_o),
    .range_bytes_o   (range_bytes_o)
  );

endmodule

// ===== src/rsfr_parser.sv =====
// rsfr_parser: front end; hunts sync, collects the frame, classifies it.
// Depends on rsfr_pkg. Pushes one frame record per checksum byte.
module rsfr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                accept_i,
  input  logic [7:0]          byte_in_i,
  output logic                push_o,
  output rsfr_pkg::frame_rec_t rec_o
);

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhLen  = 2'd1,
    PhBody = 2'd2
  } phase_e;

  phase_e     phase_q;
  logic [7:0] sync_q, ftype_q;
  logic [7:0] len_q, sum_q, type_q, cmd_q;
  logic [8:0] pos_q;
  logic [rsfr_pkg::PayloadDepth-1:0][7:0] payload_q;

  logic       at_check;
  logic [8:0] pay_idx;
  logic       pay_we;
  rsfr_pkg::status_e st;

  assign at_check = (phase_q == PhBody) && (pos_q >= {1'b0, len_q});
  assign push_o   = accept_i && at_check;
  assign pay_idx  = pos_q - 9'd2;
  assign pay_we   = accept_i && (phase_q == PhBody) && !at_check && (pos_q >= 9'd2)
                    && (pay_idx < 9'(rsfr_pkg::PayloadDepth));

  always_comb begin
    priority if (byte_in_i != sum_q) begin
      st = rsfr_pkg::StChkErr;
    end else if (len_q == 8'd0 || type_q != ftype_q) begin
      st = rsfr_pkg::StWrongType;
    end else if (len_q < 8'd2) begin
      st = rsfr_pkg::StTooShort;
    end else if (cmd_q == rsfr_pkg::CmdOdom) begin
      st = (len_q < rsfr_pkg::OdomMinLen) ? rsfr_pkg::StTooShort : rsfr_pkg::StOdom;
    end else if (cmd_q == rsfr_pkg::CmdRange) begin
      st = (len_q < rsfr_pkg::RangeMinLen) ? rsfr_pkg::StTooShort : rsfr_pkg::StRanges;
    end else begin
      st = rsfr_pkg::StOther;
    end
    rec_o.status  = st;
    rec_o.command = (st == rsfr_pkg::StChkErr || st == rsfr_pkg::StWrongType
                     || len_q < 8'd2) ? 8'd0 : cmd_q;
    rec_o.payload = payload_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      sync_q  <= rsfr_pkg::SyncReset;
      ftype_q <= rsfr_pkg::TypeReset;
      len_q   <= '0;
      sum_q   <= '0;
      type_q  <= '0;
      cmd_q   <= '0;
      pos_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rsfr_pkg::CfgSync: sync_q  <= cfg_data_i;
          rsfr_pkg::CfgType: ftype_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        unique case (phase_q)
          PhLen: begin
            len_q   <= byte_in_i;
            sum_q   <= byte_in_i;
            pos_q   <= '0;
            type_q  <= '0;
            cmd_q   <= '0;
            phase_q <= PhBody;
          end
          PhBody: begin
            if (at_check) begin
              phase_q <= PhHunt;
              pos_q   <= '0;
            end else begin
              if (pos_q == 9'd0) type_q <= byte_in_i;
              if (pos_q == 9'd1) cmd_q  <= byte_in_i;
              sum_q <= sum_q + byte_in_i;
              pos_q <= pos_q + 9'd1;
            end
          end
          default: begin
            // hunt, and the unused phase code behaves the same
            phase_q <= (byte_in_i == sync_q) ? PhLen : PhHunt;
          end
        endcase
      end
    end
  end

  // payload store: no reset, each entry is written before it is read
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      payload_q[pay_idx[3:0]] <= byte_in_i;
    end
  end

`ifndef SYNTH
  a_chk_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && rec_o.status == rsfr_pkg::StChkErr |-> rec_o.command == 8'd0)
    else $error("checksum error record carries a command");
`endif

endmodule

// ===== src/rsfr_queue.sv =====
// rsfr_queue: short queue of frame records between parser and formatter.
// Depends on rsfr_pkg for the record type and depth.
module rsfr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rsfr_pkg::frame_rec_t push_rec_i,
  input  logic                 pop_i,
  output rsfr_pkg::frame_rec_t pop_rec_o,
  output rsfr_pkg::queue_stat_t stat_o
);

  rsfr_pkg::frame_rec_t mem_q [rsfr_pkg::QueueDepth];
  logic [rsfr_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [rsfr_pkg::QueueCntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == rsfr_pkg::QueueCntW'(rsfr_pkg::QueueDepth));
  assign stat_o.valid = (cnt_q != '0);
  assign pop_rec_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == rsfr_pkg::QueuePtrW'(rsfr_pkg::QueueDepth - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == rsfr_pkg::QueuePtrW'(rsfr_pkg::QueueDepth - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !stat_o.full)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> stat_o.valid)
    else $error("pop from an empty queue");
`endif

endmodule

// ===== src/rsfr_format.sv =====
// rsfr_format: back end; turns a frame record into result fields.
// Depends on rsfr_pkg. Holds the output register of the result channel.
module rsfr_format (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rsfr_pkg::queue_stat_t qstat_i,
  input  rsfr_pkg::frame_rec_t  rec_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic [7:0]            command_o,
  output logic [15:0]           yaw_degrees_o,
  output logic signed [31:0]    left_count_o,
  output logic signed [31:0]    right_count_o,
  output logic signed [15:0]    linear_speed_o,
  output logic signed [15:0]    angular_speed_o,
  output logic [47:0]           range_bytes_o
);

  logic valid_q;
  logic is_odom, is_range;

  assign pop_o    = qstat_i.valid && (!valid_q || !out_stall_i);
  assign is_odom  = (rec_i.status == rsfr_pkg::StOdom);
  assign is_range = (rec_i.status == rsfr_pkg::StRanges);
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // zero every field that has no meaning for the status
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_o        <= 3'(rec_i.status);
      command_o       <= rec_i.command;
      yaw_degrees_o   <= is_odom ? rec_i.payload[1:0]   : '0;
      left_count_o    <= is_odom ? rec_i.payload[5:2]   : '0;
      right_count_o   <= is_odom ? rec_i.payload[9:6]   : '0;
      linear_speed_o  <= is_odom ? rec_i.payload[11:10] : '0;
      angular_speed_o <= is_odom ? rec_i.payload[13:12] : '0;
      range_bytes_o   <= is_range ? rec_i.payload[5:0]  : '0;
    end
  end

`ifndef SYNTH
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_o != 3'(rsfr_pkg::StRanges) |-> range_bytes_o == '0)
    else $error("range bytes set on a non-range result");
  a_odom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_o != 3'(rsfr_pkg::StOdom) |-> left_count_o == '0
    && right_count_o == '0 && yaw_degrees_o == '0)
    else $error("odometry fields set on a non-odometry result");
`endif

endmodule
